// ----- hw/rtl/sfsc_pkg.sv -----
`default_nettype none
package sfsc_pkg;

    // signed Q4.12 value
    typedef logic signed [15:0] t_q412;

    // stream payload widths
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 64;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AMP_OFFSET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_ERR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_X1    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PREV  = 3'd4;

    // register widths and reset values
    localparam int VMAX_W = 14;
    localparam int HALF_W = 13;
    localparam int OFF_W  = 13;
    localparam logic [VMAX_W-1:0]       VMAX_RST      = 14'd13517;
    localparam logic signed [OFF_W-1:0] OFF_RST       = 13'sd0;
    localparam t_q412                   GAIN_ERR_RST  = 16'sd941;
    localparam t_q412                   GAIN_X1_RST   = -16'sd3687;
    localparam t_q412                   GAIN_PREV_RST = 16'sd1102;

    // shared multiplier
    localparam int MUL_W  = 18;
    localparam int PROD_W = 2 * MUL_W;

    // duty mapping
    localparam int DUTY_W = 15;
    localparam logic signed [MUL_W-1:0] DUTY_SCALE = 18'sd32767;
    localparam logic signed [16:0]      DUTY_MID   = 17'sd16383;
    localparam logic signed [16:0]      DUTY_MAX   = 17'sd32767;

    // divider: |u| * 32767 < vmax * 2**15, so 15 quotient bits suffice
    localparam int DIV_NUM_W = 28;
    localparam int DIV_DEN_W = VMAX_W;
    localparam int DIV_Q_W   = 15;
    localparam int DIV_CNT_W = 4;

    // scale a code product (code * vmax / 4096) to a saturated sample
    function automatic t_q412 f_scale(input logic [VMAX_W-1:0] p,
                                      input logic [HALF_W-1:0] half,
                                      input logic signed [OFF_W-1:0] off);
        logic signed [17:0] x;
        x = $signed({4'b0, p}) - $signed({5'b0, half}) - 18'(off);
        if (x > 18'sd32767) begin
            f_scale = 16'sh7fff;
        end else if (x < -18'sd32768) begin
            f_scale = 16'sh8000;
        end else begin
            f_scale = x[15:0];
        end
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/sfsc_div.sv -----
`default_nettype none
module sfsc_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [sfsc_pkg::DIV_NUM_W-1:0] i_num,
    input  wire logic [sfsc_pkg::DIV_DEN_W-1:0] i_den,
    output logic                                o_done,
    output logic [sfsc_pkg::DIV_Q_W-1:0]        o_quot
);
    import sfsc_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_NUM_W-1:0] r_rem;
    logic [DIV_NUM_W-1:0] r_dsh;
    logic [DIV_Q_W-1:0]   r_quot;
    logic                 ge;

    // one restoring step per cycle, msb first
    assign ge = (r_rem >= r_dsh);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_Q_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_dsh  <= {i_den, (DIV_Q_W - 1)'(0)};
            r_quot <= '0;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_dsh  <= r_dsh >> 1;
            r_quot <= {r_quot[DIV_Q_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
`default_nettype wire

// ----- hw/rtl/state_feedback_saturated_controller.sv -----
`default_nettype none
// State-feedback controller with clamped output and PWM duty mapping.
// Input stream: one item per control sample (two 12-bit converter codes and
// a Q4.12 setpoint). Output stream: one item per input item carrying the PWM
// duty, the clamped control value, the clamp flag and both scaled states.
// Configuration: write channel with index and data, always ready; writes are
// taken at any time and are meant to happen only while no item is in work.
// Indexes above 4 are dropped.
// Datapath: one 18x18 multiplier is reused for both sample scalings and the
// three feedback products, then for u * 32767; a one-bit-per-cycle restoring
// divider forms the duty quotient. An item passes through sample scaling,
// feedback, clamp, duty scaling and the divide into the output register; the
// divide is skipped when full scale is zero. The block takes no new item
// while an item is in work.
// If the receiver stalls, the result waits in the output register; the next
// item may be accepted meanwhile but is not finished until it is taken.
// Reset (synchronous, active low) loads the default registers, clears the
// previous control value, drops the output valid flag and returns to idle.
module state_feedback_saturated_controller (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // input item
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [11:0] adc_first, [23:12] adc_second, [39:24] reference
    input  wire logic [sfsc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // result item
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [14:0] pwm_duty, [30:15] control_value, [31] clamped,
    // [47:32] state_first, [63:48] state_second
    output logic [sfsc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // configuration writes
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [sfsc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [sfsc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sfsc_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_M0     = 4'd1;
    localparam logic [3:0] S_X0     = 4'd2;
    localparam logic [3:0] S_X1     = 4'd3;
    localparam logic [3:0] S_A1     = 4'd4;
    localparam logic [3:0] S_A2     = 4'd5;
    localparam logic [3:0] S_A3     = 4'd6;
    localparam logic [3:0] S_CLAMP  = 4'd7;
    localparam logic [3:0] S_MSCALE = 4'd8;
    localparam logic [3:0] S_DIVST  = 4'd9;
    localparam logic [3:0] S_DIV    = 4'd10;
    localparam logic [3:0] S_FIN    = 4'd11;

    // configuration registers
    logic [VMAX_W-1:0]       r_vmax;
    logic signed [OFF_W-1:0] r_off;
    t_q412                   r_g0;
    t_q412                   r_g1;
    t_q412                   r_g2;

    // sequencer and item registers
    logic [3:0]               r_state;
    logic [3:0]               n_state;
    logic [11:0]              r_code0;
    logic [11:0]              r_code1;
    t_q412                    r_ref;
    t_q412                    r_x0;
    t_q412                    r_x1;
    t_q412                    r_prev;
    t_q412                    r_u;
    logic                     r_hit;
    logic [HALF_W-1:0]        r_half;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] r_acc;
    logic                     r_neg;
    logic [DIV_Q_W-1:0]       r_q;

    // output register
    logic                  r_ovalid;
    logic [OUT_DATA_W-1:0] r_odata;

    logic                     in_acc;
    logic                     out_free;
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [16:0]       err;
    logic signed [23:0]       u_raw;
    logic signed [23:0]       half_ext;
    logic                     hit_hi;
    logic                     hit_lo;
    logic signed [PROD_W-1:0] num_mag;
    logic                     div_start;
    logic                     div_done;
    logic [DIV_Q_W-1:0]       div_quot;
    logic signed [16:0]       duty_s;
    logic [DUTY_W-1:0]        duty;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_ovalid || m_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vmax <= VMAX_RST;
            r_off  <= OFF_RST;
            r_g0   <= GAIN_ERR_RST;
            r_g1   <= GAIN_X1_RST;
            r_g2   <= GAIN_PREV_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FULL_SCALE: r_vmax <= i_cfg_data[VMAX_W-1:0];
                REG_AMP_OFFSET: r_off  <= i_cfg_data[OFF_W-1:0];
                REG_GAIN_ERR:   r_g0   <= i_cfg_data;
                REG_GAIN_X1:    r_g1   <= i_cfg_data;
                REG_GAIN_PREV:  r_g2   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // shared multiplier operand selection
    assign err = {r_ref[15], r_ref} - {r_x0[15], r_x0};
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_M0: begin
                mul_a = $signed({6'b0, r_code0});
                mul_b = $signed({4'b0, r_vmax});
            end
            S_X0: begin
                mul_a = $signed({6'b0, r_code1});
                mul_b = $signed({4'b0, r_vmax});
            end
            S_X1: begin
                mul_a = MUL_W'(err);
                mul_b = MUL_W'(r_g0);
            end
            S_A1: begin
                mul_a = MUL_W'(r_x1);
                mul_b = MUL_W'(r_g1);
            end
            S_A2: begin
                mul_a = MUL_W'(r_prev);
                mul_b = MUL_W'(r_g2);
            end
            S_MSCALE: begin
                mul_a = MUL_W'(r_u);
                mul_b = DUTY_SCALE;
            end
            default: ;
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // clamp of the floored control value
    assign u_raw    = r_acc[35:12];
    assign half_ext = $signed({11'b0, r_half});
    assign hit_hi   = (u_raw > half_ext);
    assign hit_lo   = (u_raw < -half_ext);

    // magnitude of u * 32767 for the divider
    assign num_mag   = r_prod[PROD_W-1] ? -r_prod : r_prod;
    assign div_start = (r_state == S_DIVST) && (r_vmax != '0);

    // duty word around mid scale, saturated
    always_comb begin
        if (r_neg) begin
            duty_s = DUTY_MID - $signed({2'b0, r_q});
        end else begin
            duty_s = DUTY_MID + $signed({2'b0, r_q});
        end
        if (duty_s < 17'sd0) begin
            duty = '0;
        end else if (duty_s > DUTY_MAX) begin
            duty = DUTY_MAX[DUTY_W-1:0];
        end else begin
            duty = duty_s[DUTY_W-1:0];
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (in_acc) n_state = S_M0;
            S_M0:     n_state = S_X0;
            S_X0:     n_state = S_X1;
            S_X1:     n_state = S_A1;
            S_A1:     n_state = S_A2;
            S_A2:     n_state = S_A3;
            S_A3:     n_state = S_CLAMP;
            S_CLAMP:  n_state = S_MSCALE;
            S_MSCALE: n_state = S_DIVST;
            S_DIVST:  n_state = (r_vmax == '0) ? S_FIN : S_DIV;
            S_DIV:    if (div_done) n_state = S_FIN;
            S_FIN:    if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_prev   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLAMP) begin
                r_prev <= hit_hi ? t_q412'(half_ext) :
                          hit_lo ? t_q412'(-half_ext) : u_raw[15:0];
            end
            if (r_state == S_FIN && out_free) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_code0 <= s_axis_tdata[11:0];
            r_code1 <= s_axis_tdata[23:12];
            r_ref   <= s_axis_tdata[39:24];
        end
        case (r_state)
            S_M0: begin
                r_half <= r_vmax[VMAX_W-1:1];
                r_prod <= mul_p;
            end
            S_X0: begin
                r_x0   <= f_scale(r_prod[25:12], r_half, r_off);
                r_prod <= mul_p;
            end
            S_X1: begin
                r_x1   <= f_scale(r_prod[25:12], r_half, r_off);
                r_prod <= mul_p;
            end
            S_A1: begin
                r_acc  <= r_prod;
                r_prod <= mul_p;
            end
            S_A2: begin
                r_acc  <= r_acc - r_prod;
                r_prod <= mul_p;
            end
            S_A3: r_acc <= r_acc - r_prod;
            S_CLAMP: begin
                r_u   <= hit_hi ? t_q412'(half_ext) :
                         hit_lo ? t_q412'(-half_ext) : u_raw[15:0];
                r_hit <= hit_hi || hit_lo;
            end
            S_MSCALE: r_prod <= mul_p;
            S_DIVST: begin
                r_neg <= r_prod[PROD_W-1];
                r_q   <= '0;
            end
            S_DIV: if (div_done) r_q <= div_quot;
            default: ;
        endcase
        if (r_state == S_FIN && out_free) begin
            r_odata <= {r_x1, r_x0, r_hit, r_u, duty};
        end
    end

    // quotient unit for the duty
    sfsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num_mag[DIV_NUM_W-1:0]),
        .i_den   (r_vmax),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    // an accepted item blocks the input until it is finished
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !s_axis_tready)
        else $error("input ready right after an item was accepted");

    // clamped control value stays inside the half range
    a_clamp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLAMP) |=>
            ($signed({8'b0, r_u}) <= $signed({11'b0, r_half}) &&
             $signed({8'b0, r_u}) >= -$signed({11'b0, r_half})) ||
            (r_u[15] && $signed(r_u) >= -$signed({3'b0, r_half})))
        else $error("control value outside the clamp limits");

    // divider reports completion only while the sequencer waits for it
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider done outside the divide state");

    // a finished result is never overwritten while still waiting
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !m_axis_tready) |=> $stable(r_odata))
        else $error("pending result changed under a stall");

endmodule
`default_nettype wire
